@@ rtl/core/tgi_pkg.sv @@
// Package: shared constants and types for the trilinear grid interpolator
package tgi_pkg;
    localparam int unsigned NX_DEF = 16;
    localparam int unsigned NY_DEF = 16;
    localparam int unsigned NZ_DEF = 16;
    localparam int unsigned TBL_AW = 12;
    localparam int unsigned TBL_DEPTH = 4096;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned INV_W = 31;
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned IDX_W = 8;
    localparam int unsigned FRAC_W = 17;

    localparam logic [CFG_AW-1:0] REG_X_ORG = 3'd0;
    localparam logic [CFG_AW-1:0] REG_Y_ORG = 3'd1;
    localparam logic [CFG_AW-1:0] REG_Z_ORG = 3'd2;
    localparam logic [CFG_AW-1:0] REG_X_INV = 3'd3;
    localparam logic [CFG_AW-1:0] REG_Y_INV = 3'd4;
    localparam logic [CFG_AW-1:0] REG_Z_INV = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one axis after locating: cell index and fraction (0..65536)
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
    } t_axis;
endpackage

@@ rtl/core/tgi_ram.sv @@
// Generic single-port RAM with registered read
module tgi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/tgi_locate.sv @@
// Axis locator: (q - origin) * inv_step, clamp, split to index and fraction
module tgi_locate #(
    parameter int unsigned N = tgi_pkg::NX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [tgi_pkg::VAL_W-1:0] i_q,
    input  logic signed [tgi_pkg::VAL_W-1:0] i_org,
    input  logic [tgi_pkg::INV_W-1:0]        i_inv,
    output tgi_pkg::t_axis                   o_axis
);
    localparam logic [63:0] TOP = 64'(N - 1) << 32;
    localparam logic [tgi_pkg::IDX_W-1:0] LAST = tgi_pkg::IDX_W'(N - 2);

    logic signed [32:0] r_d;
    logic [tgi_pkg::INV_W-1:0] r_inv;
    logic signed [63:0] r_p;
    logic signed [63:0] n_p;
    tgi_pkg::t_axis r_axis;
    tgi_pkg::t_axis n_axis;

    // stage 1: difference; stage 2: product; stage 3: clamp
    assign n_p = 64'(r_d * $signed({1'b0, r_inv}));

    always_comb begin
        if (r_p <= 0) begin
            n_axis.idx  = '0;
            n_axis.frac = '0;
        end else if (r_p >= $signed(TOP)) begin
            n_axis.idx  = LAST;
            n_axis.frac = tgi_pkg::FRAC_W'(65536);
        end else begin
            n_axis.idx  = r_p[32 +: tgi_pkg::IDX_W];
            n_axis.frac = {1'b0, r_p[31:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= 33'(i_q) - 33'(i_org);
            r_inv  <= i_inv;
            r_p    <= n_p;
            r_axis <= n_axis;
        end
    end

    assign o_axis = r_axis;
endmodule

@@ rtl/core/tgi_blend.sv @@
// Blend unit: a + floor((b - a) * t / 65536), registered
module tgi_blend (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    input  logic [tgi_pkg::FRAC_W-1:0] i_t,
    output logic signed [33:0] o_y
);
    logic signed [52:0] w_v;
    logic signed [33:0] r_y;

    // arithmetic shift floors toward minus infinity
    assign w_v = 53'(35'(i_b) - 35'(i_a)) * $signed({1'b0, i_t});

    always_ff @(posedge i_clk) begin
        r_y <= i_a + 34'(w_v >>> 16);
    end

    assign o_y = r_y;
endmodule

@@ rtl/core/trilinear_grid_interpolator_core.sv @@
// Top level: trilinear interpolator over a 3-D Q16.16 table
// A request is taken at a clock edge where start is high and busy is low. A write
// stores one table entry in that cycle, gives no result and leaves busy low, so
// writes can follow each other every cycle. A query raises busy while the locators
// find cell and fraction on each axis and the eight corners are read one per cycle
// from the single-port table RAM; no new request of any kind is taken until the
// corner reads are done. The result strobes for one cycle once the corner reads,
// three blend stages and saturation are through; the receiver cannot stall results.
module trilinear_grid_interpolator_core #(
    parameter int unsigned NX = tgi_pkg::NX_DEF,
    parameter int unsigned NY = tgi_pkg::NY_DEF,
    parameter int unsigned NZ = tgi_pkg::NZ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [tgi_pkg::TBL_AW-1:0]  i_entry_addr,
    input  logic signed [31:0]          i_entry_value,
    input  logic signed [31:0]          i_query_x,
    input  logic signed [31:0]          i_query_y,
    input  logic signed [31:0]          i_query_z,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tgi_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_strobe,
    output logic signed [31:0]          o_interp_value
);
    localparam int unsigned AW = tgi_pkg::TBL_AW;
    localparam int unsigned LOC_LAT = 3;

    // configuration registers
    logic signed [31:0] r_xo, r_yo, r_zo;
    logic [tgi_pkg::INV_W-1:0] r_xi, r_yi, r_zi;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xo <= '0; r_yo <= '0; r_zo <= '0;
            r_xi <= 31'd65536; r_yi <= 31'd65536; r_zi <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tgi_pkg::REG_X_ORG: r_xo <= i_cfg_data;
                tgi_pkg::REG_Y_ORG: r_yo <= i_cfg_data;
                tgi_pkg::REG_Z_ORG: r_zo <= i_cfg_data;
                tgi_pkg::REG_X_INV: r_xi <= i_cfg_data[30:0];
                tgi_pkg::REG_Y_INV: r_yi <= i_cfg_data[30:0];
                tgi_pkg::REG_Z_INV: r_zi <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // request acceptance; locator pipeline runs every cycle
    logic acc, acc_q, acc_w;
    assign acc   = start && !busy;
    assign acc_q = acc && (i_op == tgi_pkg::OP_QUERY);
    assign acc_w = acc && (i_op == tgi_pkg::OP_WRITE);

    tgi_pkg::t_axis ax, ay, az;
    tgi_locate #(.N(NX)) u_lx (.i_clk, .i_en(1'b1), .i_q(i_query_x), .i_org(r_xo),
        .i_inv(r_xi), .o_axis(ax));
    tgi_locate #(.N(NY)) u_ly (.i_clk, .i_en(1'b1), .i_q(i_query_y), .i_org(r_yo),
        .i_inv(r_yi), .o_axis(ay));
    tgi_locate #(.N(NZ)) u_lz (.i_clk, .i_en(1'b1), .i_q(i_query_z), .i_org(r_zo),
        .i_inv(r_zi), .o_axis(az));

    // query lifecycle: locate, then 8 corner reads; busy throughout,
    // so no write can take the table port from a corner read
    logic [LOC_LAT-1:0] r_loc;
    logic r_rd;
    logic [2:0] r_cnt;
    tgi_pkg::t_axis r_ax, r_ay, r_az;
    logic [AW-1:0] r_base;
    logic busy_loc;
    assign busy_loc = |r_loc;
    assign busy = busy_loc || r_rd;

    // base address from located indices (two multiply-adds, registered)
    logic [AW-1:0] n_base;
    assign n_base = AW'((32'(ax.idx) * NY + 32'(ay.idx)) * NZ + 32'(az.idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc <= '0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_loc <= {r_loc[LOC_LAT-2:0], acc_q};
            if (r_loc[LOC_LAT-1]) begin
                r_rd  <= 1'b1;
                r_cnt <= '0;
            end else if (r_rd) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) r_rd <= 1'b0;
            end
        end
        if (r_loc[LOC_LAT-1]) begin
            r_ax <= ax; r_ay <= ay; r_az <= az;
            r_base <= n_base;
        end
    end

    // corner offset: bit0 x, bit1 y, bit2 z
    logic [AW-1:0] off, rd_addr;
    always_comb begin
        off = '0;
        if (r_cnt[0]) off = off + AW'(NY * NZ);
        if (r_cnt[1]) off = off + AW'(NZ);
        if (r_cnt[2]) off = off + AW'(1);
        rd_addr = r_base + off;
    end

    // table memory: write from request, else corner read
    logic [31:0] rdata;
    tgi_ram #(.WIDTH(32), .DEPTH(tgi_pkg::TBL_DEPTH)) u_tbl (
        .i_clk, .i_we(acc_w),
        .i_addr(acc_w ? i_entry_addr : rd_addr),
        .i_wdata(i_entry_value), .o_rdata(rdata));

    // collect corners: data for count c appears in the cycle after its read
    logic r_dv;
    logic [2:0] r_dc;
    logic signed [31:0] r_c [8];
    logic [tgi_pkg::FRAC_W-1:0] r_tx, r_ty, r_tz;
    logic r_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_dv <= r_rd;
            r_go <= r_dv && r_dc == 3'd7;
        end
        r_dc <= r_cnt;
        if (r_dv) r_c[r_dc] <= rdata;
        if (r_rd && r_cnt == 3'd7) begin
            r_tx <= r_ax.frac; r_ty <= r_ay.frac; r_tz <= r_az.frac;
        end
    end

    // blend tree: four x blends, two y, one z; each registered
    logic signed [33:0] bx [4];
    logic signed [33:0] by [2];
    logic signed [33:0] bz;
    genvar g;
    for (g = 0; g < 4; g++) begin : g_bx
        tgi_blend u_b (.i_clk, .i_a(34'(r_c[2*g])), .i_b(34'(r_c[2*g+1])),
            .i_t(r_tx), .o_y(bx[g]));
    end
    for (g = 0; g < 2; g++) begin : g_by
        tgi_blend u_b (.i_clk, .i_a(bx[2*g]), .i_b(bx[2*g+1]), .i_t(r_ty),
            .o_y(by[g]));
    end
    tgi_blend u_bz (.i_clk, .i_a(by[0]), .i_b(by[1]), .i_t(r_tz), .o_y(bz));

    // strobe delay and saturation; fractions are captured once per query
    // (the next capture comes after the blend of this query is done)
    logic [2:0] r_vp;
    logic signed [31:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= '0;
        else r_vp <= {r_vp[1:0], r_go};
        if (bz > 34'sd2147483647) r_out <= 32'h7fffffff;
        else if (bz < -34'sd2147483648) r_out <= 32'h80000000;
        else r_out <= bz[31:0];
    end
    logic r_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= 1'b0;
        else r_st <= r_vp[2];
    end
    assign o_strobe = r_st;
    assign o_interp_value = r_out;
endmodule

@@ rtl/core/tgi_checker.sv @@
// Port-level checker for the interpolator, bound to the top level
module tgi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_op,
    input logic o_strobe
);
    a_busy_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op |=> busy) else $error("query not held busy");
    a_no_strobe_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe after reset");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("repeated strobe");
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_op && !$past(busy) |=> !busy || $past(busy))
        else $error("write raised busy");
endmodule

bind trilinear_grid_interpolator_core tgi_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .i_op, .o_strobe);

@@ tb/sv/tgi_interp_checker.sv @@
// Checker: watches the interpolator channels, predicts each query result and compares
module tgi_interp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_op,
    input  logic [11:0]        i_entry_addr,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    input  logic signed [31:0] i_query_z,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               o_strobe,
    input  logic signed [31:0] o_interp_value,
    output int                 o_pending,
    output int                 o_fail_count
);
    // shadow of the block's state
    logic signed [31:0] grid_value [tgi_pkg::TBL_DEPTH];
    logic signed [31:0] org_q [3];
    logic [30:0]        inv_q [3];
    logic signed [31:0] expected_value [$];
    int                 fails;

    assign o_fail_count = fails;

    // map one coordinate to cell index and fraction (0..65536)
    function automatic void find_cell(input logic signed [31:0] q, input logic signed [31:0] org,
                                      input logic [30:0] inv, input int unsigned n,
                                      output int unsigned idx, output int unsigned frac);
        longint d;
        longint p;
        longint last;
        d = longint'(q) - longint'(org);
        p = d * longint'({33'd0, inv});
        last = longint'(n - 1) << 32;
        if (p <= 0) begin
            idx = 0;
            frac = 0;
        end else if (p >= last) begin
            idx = n - 2;
            frac = 65536;
        end else begin
            idx = int'(p >>> 32);
            frac = int'((p >>> 16) & 64'hFFFF);
        end
    endfunction

    // a + floor((b - a) * t / 65536)
    function automatic longint lerp(input longint a, input longint b, input int unsigned t);
        longint v;
        v = (b - a) * longint'(t);
        return a + (v >>> 16);
    endfunction

    function automatic longint grid_at(input int unsigned i, input int unsigned j,
                                       input int unsigned k);
        return longint'(grid_value[((i * tgi_pkg::NY_DEF + j) * tgi_pkg::NZ_DEF + k)
                                   & (tgi_pkg::TBL_DEPTH - 1)]);
    endfunction

    function automatic logic signed [31:0] interp_point(input logic signed [31:0] qx,
                                                        input logic signed [31:0] qy,
                                                        input logic signed [31:0] qz);
        int unsigned i, j, k, tx, ty, tz;
        longint c00, c10, c01, c11, e0, e1, r;
        find_cell(qx, org_q[0], inv_q[0], tgi_pkg::NX_DEF, i, tx);
        find_cell(qy, org_q[1], inv_q[1], tgi_pkg::NY_DEF, j, ty);
        find_cell(qz, org_q[2], inv_q[2], tgi_pkg::NZ_DEF, k, tz);
        c00 = lerp(grid_at(i, j, k), grid_at(i + 1, j, k), tx);
        c10 = lerp(grid_at(i, j + 1, k), grid_at(i + 1, j + 1, k), tx);
        c01 = lerp(grid_at(i, j, k + 1), grid_at(i + 1, j, k + 1), tx);
        c11 = lerp(grid_at(i, j + 1, k + 1), grid_at(i + 1, j + 1, k + 1), tx);
        e0 = lerp(c00, c10, ty);
        e1 = lerp(c01, c11, ty);
        r = lerp(e0, e1, tz);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    initial begin
        fails = 0;
        o_pending = 0;
        foreach (grid_value[a]) grid_value[a] = '0;
        foreach (org_q[a]) begin
            org_q[a] = '0;
            inv_q[a] = 31'd65536;
        end
    end

    // track requests, register writes and results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tgi_pkg::REG_X_ORG: org_q[0] <= i_cfg_data;
                    tgi_pkg::REG_Y_ORG: org_q[1] <= i_cfg_data;
                    tgi_pkg::REG_Z_ORG: org_q[2] <= i_cfg_data;
                    tgi_pkg::REG_X_INV: inv_q[0] <= i_cfg_data[30:0];
                    tgi_pkg::REG_Y_INV: inv_q[1] <= i_cfg_data[30:0];
                    tgi_pkg::REG_Z_INV: inv_q[2] <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_op == tgi_pkg::OP_WRITE)
                    grid_value[i_entry_addr] <= i_entry_value;
                else
                    expected_value.push_back(interp_point(i_query_x, i_query_y, i_query_z));
            end
            if (o_strobe) begin
                if (expected_value.size() == 0) begin
                    fails <= fails + 1;
                    if (fails < 10)
                        $display("unexpected result %h", o_interp_value);
                end else begin
                    if (o_interp_value !== expected_value[0]) begin
                        fails <= fails + 1;
                        if (fails < 10)
                            $display("interp_value: expected %h, got %h",
                                     expected_value[0], o_interp_value);
                    end
                    void'(expected_value.pop_front());
                end
            end
        end
        o_pending <= expected_value.size();
    end
endmodule

@@ tb/sv/tb_trilinear_grid_interpolator_core.sv @@
// Testbench top: drives requests and register writes, gives the verdict
module tb_trilinear_grid_interpolator_core;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_op = tgi_pkg::OP_WRITE;
    logic [11:0]        i_entry_addr = '0;
    logic signed [31:0] i_entry_value = '0;
    logic signed [31:0] i_query_x = '0;
    logic signed [31:0] i_query_y = '0;
    logic signed [31:0] i_query_z = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_strobe;
    logic signed [31:0] o_interp_value;
    int                 pending;
    int                 fail_count;
    int                 cycles = 0;
    int                 idle_pct = 0;

    // idle share per phase, and the grid points per axis that the table holds
    int                 pct [8] = '{0, 80, 35, 0, 80, 35, 0, 80};
    int                 fill_cells [6] = '{0, 1, 2, 3, 14, 15};

    // stimulus-side copy of the axis settings, used to aim queries
    logic signed [31:0] org_set [3] = '{default: '0};
    logic [30:0]        inv_set [3] = '{default: 31'd65536};

    trilinear_grid_interpolator_core dut (.*);

    tgi_interp_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_entry_addr, .i_entry_value,
        .i_query_x, .i_query_y, .i_query_z, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_strobe, .o_interp_value,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one request; start stays high unless an idle gap follows
    task automatic send_req(input logic op, input logic [11:0] addr, input logic [31:0] val,
                            input logic [31:0] qx, input logic [31:0] qy,
                            input logic [31:0] qz);
        start <= 1'b1;
        i_op <= op;
        i_entry_addr <= addr;
        i_entry_value <= val;
        i_query_x <= qx;
        i_query_y <= qy;
        i_query_z <= qz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // register write; the caller lowers valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tgi_pkg::REG_X_ORG: org_set[0] = data;
            tgi_pkg::REG_Y_ORG: org_set[1] = data;
            tgi_pkg::REG_Z_ORG: org_set[2] = data;
            tgi_pkg::REG_X_INV: inv_set[0] = data[30:0];
            tgi_pkg::REG_Y_INV: inv_set[1] = data[30:0];
            tgi_pkg::REG_Z_INV: inv_set[2] = data[30:0];
            default: ;
        endcase
    endtask

    task automatic set_axes(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz);
        write_reg(tgi_pkg::REG_X_ORG, ox);
        write_reg(tgi_pkg::REG_Y_ORG, oy);
        write_reg(tgi_pkg::REG_Z_ORG, oz);
        write_reg(tgi_pkg::REG_X_INV, vx);
        write_reg(tgi_pkg::REG_Y_INV, vy);
        write_reg(tgi_pkg::REG_Z_INV, vz);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for all results, then let a trailing write settle
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // coordinate whose cell only touches filled grid points: low cells or the top cell
    function automatic logic [31:0] aim(input int axis);
        longint inv;
        longint span;
        longint lo;
        longint off;
        longint p;
        logic [31:0] q;
        inv = longint'({33'd0, inv_set[axis]});
        for (int n = 0; n < 16; n++) begin
            if ($urandom_range(99) < 20) begin
                q = $urandom;
            end else begin
                lo = 0;
                span = 64'sd1 <<< 32;
                if (inv != 0) begin
                    lo = ($urandom_range(99) < 70) ? 64'sd0 : (64'sd13 <<< 32) / inv;
                    span = (64'sd3 <<< 32) / inv;
                end
                if (span > (64'sd1 <<< 32)) span = 64'sd1 <<< 32;
                off = lo + longint'({$urandom, $urandom} % (span + span / 4 + 1)) - span / 8;
                q = org_set[axis] + off[31:0];
            end
            p = (longint'($signed(q)) - longint'(org_set[axis])) * inv;
            if (p < (64'sd3 <<< 32) || p >= (64'sd14 <<< 32)) return q;
        end
        return org_set[axis];
    endfunction

    task automatic random_reqs(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 25)
                send_req(tgi_pkg::OP_WRITE, 12'($urandom), $urandom, $urandom, $urandom,
                         $urandom);
            else
                send_req(tgi_pkg::OP_QUERY, 12'($urandom), $urandom, aim(0), aim(1), aim(2));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the first four and last two grid points of each axis; queries stay there
        foreach (fill_cells[a])
            foreach (fill_cells[b])
                foreach (fill_cells[c])
                    send_req(tgi_pkg::OP_WRITE,
                             12'((fill_cells[a] * tgi_pkg::NY_DEF + fill_cells[b])
                                 * tgi_pkg::NZ_DEF + fill_cells[c]),
                             $urandom, $urandom, $urandom, $urandom);
        send_req(tgi_pkg::OP_WRITE, 12'd0, 32'h7FFF_FFFF, '0, '0, '0);
        send_req(tgi_pkg::OP_WRITE, 12'd4095, 32'h8000_0000, '0, '0, '0);
        send_req(tgi_pkg::OP_WRITE, 12'd1, 32'h8000_0000, '0, '0, '0);
        send_req(tgi_pkg::OP_WRITE, 12'd16, 32'h7FFF_FFFF, '0, '0, '0);

        // directed queries at reset settings: below, on points, between, above
        send_req(tgi_pkg::OP_QUERY, 12'hFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h0000_8000, 32'h0000_0001, 32'h0000_FFFF);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h0002_8000, 32'h0002_4000, 32'h000E_C000);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0010_0000);
        send_req(tgi_pkg::OP_QUERY, '0, '0, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0000);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: set_axes(32'hFFFF_0000, 32'h0000_8000, 32'h0,
                            32'd131072, 32'd32768, 32'd65536);
                2: set_axes(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                            32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
                3: set_axes(32'h0, 32'h0, 32'hFFF0_0000,
                            32'h8000_0000, 32'd0, 32'd65536);
                default: begin
                    // unused register indexes must change nothing
                    write_reg(3'd6, $urandom);
                    write_reg(3'd7, $urandom);
                    set_axes($urandom, $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000,
                             $urandom_range(0, 32'h0010_0000),
                             $urandom_range(4096, 1 << 20), $urandom_range(4096, 1 << 20),
                             32'h8000_0000 | $urandom_range(4096, 1 << 20));
                end
            endcase
            idle_pct = pct[ph];
            random_reqs(40);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ trilinear_grid_interpolator_core.f @@
rtl/core/tgi_pkg.sv
rtl/core/tgi_ram.sv
rtl/core/tgi_locate.sv
rtl/core/tgi_blend.sv
rtl/core/trilinear_grid_interpolator_core.sv
rtl/core/tgi_checker.sv
tb/sv/tgi_interp_checker.sv
tb/sv/tb_trilinear_grid_interpolator_core.sv
